// ----- rtl/core/tes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event sequencer package
// Shared types and codes for the event table, the sequencing control and the
// output register.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  localparam logic [1:0] MODE_DIRECT  = 2'd0;
  localparam logic [1:0] MODE_TOGGLE  = 2'd1;
  localparam logic [1:0] MODE_ONESHOT = 2'd2;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_TRIG    = 3'd1;
  localparam logic [2:0] KIND_STOP    = 3'd2;
  localparam logic [2:0] KIND_ADDED   = 3'd3;
  localparam logic [2:0] KIND_REFUSED = 3'd4;

  localparam logic REG_BUTTON_MODE = 1'b0;
  localparam logic REG_LOOP_ENABLE = 1'b1;

  localparam int MAX_RESULTS = 16;
  localparam int ECW         = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [31:0] time_ms;
    logic        stop;
    logic        has;
    logic [7:0]  act;
  } entry_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] act;
    logic       playing;
    logic       last;
  } res_t;

endpackage

// ----- rtl/core/tes_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event table memory
// Synchronous memory of event entries with one write port and one read port
// whose data is registered.
// ----------------------------------------------------------------------------
module tes_mem #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tes_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output tes_pkg::entry_t rdata
);

  tes_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/tes_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output register
// Holds one result word towards the receiver and reports when it can be
// loaded again.
// ----------------------------------------------------------------------------
module tes_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  tes_pkg::res_t word,
  output logic          free,
  output logic          out_valid,
  input  logic          out_stall,
  output tes_pkg::res_t out_word
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= word;
    end
  end

endmodule

// ----- rtl/core/tes_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer control
// Accepts items, applies the button rules, walks the event table for
// insertion, dispatch and stop, and hands result words to the output.
// ----------------------------------------------------------------------------
module tes_ctrl #(
  parameter int MAX_EVENTS = 16,
  localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1,
  localparam int CW = $clog2(MAX_EVENTS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      opcode,
  input  logic [31:0]     now_ms,
  input  logic            button_pressed,
  input  logic [31:0]     event_time,
  input  logic            event_is_stop,
  input  logic [7:0]      action_id,
  input  logic            has_action,
  input  logic            write_enable,
  input  logic            reg_index,
  input  logic [1:0]      write_data,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output tes_pkg::entry_t mem_wdata,
  output logic            mem_re,
  output logic [AW-1:0]   mem_raddr,
  input  tes_pkg::entry_t mem_rdata,
  input  logic            out_free,
  output logic            push,
  output tes_pkg::res_t   push_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_STOP = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [CW-1:0] FULL = CW'(MAX_EVENTS);

  logic [2:0] state, state_next;
  logic [CW-1:0] event_count, event_count_next;
  logic [CW-1:0] next_event, next_event_next;
  logic [CW-1:0] idx, idx_next;
  logic playing, playing_next;
  logic latched_on, latched_on_next;
  logic button_was_pressed, button_was_pressed_next;
  logic fin_playing, fin_playing_next;
  logic [31:0] start_time, start_time_next;
  logic [31:0] elapsed, elapsed_next;
  logic [1:0] button_mode;
  logic loop_enable;
  logic hold_valid, hold_valid_next;
  logic [2:0] hold_kind, hold_kind_next;
  logic [7:0] hold_act, hold_act_next;
  logic [tes_pkg::ECW-1:0] ec, ec_next;

  logic [31:0] now_q;
  tes_pkg::entry_t new_q;

  logic rule_begin, rule_stop, rule_latched;
  logic [CW-1:0] count_m1, idx_inc, idx_dec;
  logic due, gen, step_ok;
  logic [2:0] gen_kind;
  tes_pkg::entry_t new_in;

  assign in_stall = (state != S_IDLE);
  assign count_m1 = event_count - CW'(1);
  assign idx_inc  = idx + CW'(1);
  assign idx_dec  = idx - CW'(1);
  assign new_in   = '{time_ms: event_time, stop: event_is_stop, has: has_action,
                      act: action_id};

  always_comb begin
    rule_begin   = 1'b0;
    rule_stop    = 1'b0;
    rule_latched = latched_on;
    case (button_mode)
      tes_pkg::MODE_DIRECT: begin
        if (button_pressed && !latched_on && !button_was_pressed) begin
          rule_latched = 1'b1;
          rule_begin   = 1'b1;
        end else if (!button_pressed && latched_on && button_was_pressed) begin
          rule_latched = 1'b0;
          rule_stop    = 1'b1;
        end
      end
      tes_pkg::MODE_TOGGLE: begin
        if (button_pressed && !latched_on && !button_was_pressed) begin
          rule_latched = 1'b1;
          rule_begin   = 1'b1;
        end else if (button_pressed && latched_on && !button_was_pressed) begin
          rule_latched = 1'b0;
          rule_stop    = 1'b1;
        end
      end
      tes_pkg::MODE_ONESHOT: begin
        rule_begin = button_pressed && !button_was_pressed;
      end
      default: begin
      end
    endcase
  end

  assign due      = (idx < event_count) && (mem_rdata.time_ms <= elapsed);
  assign gen_kind = (state == S_WALK && !mem_rdata.stop) ? tes_pkg::KIND_TRIG
                                                        : tes_pkg::KIND_STOP;
  assign gen      = mem_rdata.has && (ec < tes_pkg::ECW'(tes_pkg::MAX_RESULTS));
  assign step_ok  = !gen || !hold_valid || out_free;

  always_comb begin
    state_next              = state;
    event_count_next        = event_count;
    next_event_next         = next_event;
    idx_next                = idx;
    playing_next            = playing;
    latched_on_next         = latched_on;
    button_was_pressed_next = button_was_pressed;
    fin_playing_next        = fin_playing;
    start_time_next         = start_time;
    elapsed_next            = elapsed;
    hold_valid_next         = hold_valid;
    hold_kind_next          = hold_kind;
    hold_act_next           = hold_act;
    ec_next                 = ec;
    mem_we                  = 1'b0;
    mem_waddr               = idx[AW-1:0];
    mem_wdata               = new_q;
    mem_re                  = 1'b0;
    mem_raddr               = idx_inc[AW-1:0];
    push                    = 1'b0;
    push_word               = '{kind: hold_kind, act: hold_act, playing: fin_playing,
                                last: 1'b0};
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (opcode)
            tes_pkg::OP_ADD: begin
              fin_playing_next = playing;
              if (event_count >= FULL) begin
                hold_valid_next = 1'b1;
                hold_kind_next  = tes_pkg::KIND_REFUSED;
                hold_act_next   = 8'd0;
                ec_next         = tes_pkg::ECW'(1);
                state_next      = S_FIN;
              end else if (event_count == '0) begin
                mem_we           = 1'b1;
                mem_waddr        = '0;
                mem_wdata        = new_in;
                event_count_next = CW'(1);
                hold_valid_next  = 1'b1;
                hold_kind_next   = tes_pkg::KIND_ADDED;
                hold_act_next    = 8'd0;
                ec_next          = tes_pkg::ECW'(1);
                state_next       = S_FIN;
              end else begin
                idx_next   = count_m1;
                mem_re     = 1'b1;
                mem_raddr  = count_m1[AW-1:0];
                state_next = S_INS;
              end
            end
            tes_pkg::OP_TICK: begin
              button_was_pressed_next = button_pressed;
              latched_on_next         = rule_latched;
              if (rule_stop) begin
                playing_next     = 1'b0;
                fin_playing_next = 1'b0;
                idx_next         = '0;
                mem_re           = 1'b1;
                mem_raddr        = '0;
                state_next       = S_STOP;
              end else begin
                if (rule_begin) begin
                  playing_next    = 1'b1;
                  start_time_next = now_ms;
                  next_event_next = '0;
                  elapsed_next    = 32'd0;
                end else begin
                  elapsed_next = now_ms - start_time;
                end
                if ((playing || rule_begin) && event_count != '0) begin
                  mem_re     = 1'b1;
                  mem_raddr  = count_m1[AW-1:0];
                  state_next = S_LAST;
                end else begin
                  fin_playing_next = playing || rule_begin;
                  state_next       = S_FIN;
                end
              end
            end
            tes_pkg::OP_START: begin
              playing_next     = 1'b1;
              start_time_next  = now_ms;
              next_event_next  = '0;
              fin_playing_next = 1'b1;
              state_next       = S_FIN;
            end
            default: begin
              playing_next     = 1'b0;
              fin_playing_next = 1'b0;
              idx_next         = '0;
              mem_re           = 1'b1;
              mem_raddr        = '0;
              state_next       = S_STOP;
            end
          endcase
        end
      end
      S_INS: begin
        if (mem_rdata.time_ms > new_q.time_ms) begin
          mem_we    = 1'b1;
          mem_waddr = idx_inc[AW-1:0];
          mem_wdata = mem_rdata;
          if (idx == '0) begin
            state_next = S_PUT;
          end else begin
            idx_next  = idx_dec;
            mem_re    = 1'b1;
            mem_raddr = idx_dec[AW-1:0];
          end
        end else begin
          idx_next   = idx_inc;
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        mem_we           = 1'b1;
        event_count_next = event_count + CW'(1);
        hold_valid_next  = 1'b1;
        hold_kind_next   = tes_pkg::KIND_ADDED;
        hold_act_next    = 8'd0;
        ec_next          = tes_pkg::ECW'(1);
        state_next       = S_FIN;
      end
      S_LAST: begin
        if (next_event >= event_count || mem_rdata.time_ms <= elapsed) begin
          fin_playing_next = loop_enable;
        end else begin
          fin_playing_next = 1'b1;
        end
        idx_next   = next_event;
        mem_re     = 1'b1;
        mem_raddr  = next_event[AW-1:0];
        state_next = S_WALK;
      end
      S_WALK, S_STOP: begin
        if ((state == S_WALK && !due) || (state == S_STOP && idx >= event_count)) begin
          if (state == S_WALK) begin
            next_event_next = idx;
            if (idx >= event_count) begin
              if (loop_enable) begin
                start_time_next = now_q;
                next_event_next = '0;
              end else begin
                playing_next = 1'b0;
              end
            end
          end
          state_next = S_FIN;
        end else if (step_ok) begin
          if (gen) begin
            push            = hold_valid;
            hold_valid_next = 1'b1;
            hold_kind_next  = gen_kind;
            hold_act_next   = mem_rdata.act;
            ec_next         = ec + tes_pkg::ECW'(1);
          end
          idx_next = idx_inc;
          mem_re   = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          push            = 1'b1;
          push_word.kind  = hold_valid ? hold_kind : tes_pkg::KIND_NONE;
          push_word.act   = hold_valid ? hold_act : 8'd0;
          push_word.last  = 1'b1;
          hold_valid_next = 1'b0;
          ec_next         = '0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      event_count        <= '0;
      next_event         <= '0;
      idx                <= '0;
      playing            <= 1'b0;
      latched_on         <= 1'b0;
      button_was_pressed <= 1'b0;
      fin_playing        <= 1'b0;
      start_time         <= 32'd0;
      elapsed            <= 32'd0;
      hold_valid         <= 1'b0;
      ec                 <= '0;
      button_mode        <= 2'd0;
      loop_enable        <= 1'b0;
    end else begin
      state              <= state_next;
      event_count        <= event_count_next;
      next_event         <= next_event_next;
      idx                <= idx_next;
      playing            <= playing_next;
      latched_on         <= latched_on_next;
      button_was_pressed <= button_was_pressed_next;
      fin_playing        <= fin_playing_next;
      start_time         <= start_time_next;
      elapsed            <= elapsed_next;
      hold_valid         <= hold_valid_next;
      ec                 <= ec_next;
      if (write_enable) begin
        case (reg_index)
          tes_pkg::REG_BUTTON_MODE: button_mode <= write_data;
          tes_pkg::REG_LOOP_ENABLE: loop_enable <= write_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_kind <= hold_kind_next;
    hold_act  <= hold_act_next;
    if (state == S_IDLE && in_valid) begin
      now_q <= now_ms;
      new_q <= new_in;
    end
  end

endmodule

// ----- rtl/core/timed_event_sequencer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event sequencer
// Keeps a time-sorted event table and turns ticks into action commands.
// ----------------------------------------------------------------------------
// Input words (opcode with fields) are taken on in_valid while in_stall is
// low; in_stall is high for the whole time one word is being worked on. Each
// word yields one or more result words on the output channel, the final one
// marked by last_result, and every result word carries the playback flag as
// it stands after the whole input word.
// The walk over the event table memory reads one entry per cycle unless it
// pauses as described below; the read data is registered:
//   add   : an empty table takes the entry at once and a full table refuses
//           it; otherwise entries later than the new one move up one place,
//           from the end down, and the new entry is then written in place
//   tick  : with playback on and a non-empty table, reads the last entry and
//           then walks the due entries; a button stop walks the whole table
//   stop  : walks the whole table; start : sets playback without a walk
// A stalled receiver holds the output register; the walk pauses only when a
// command is ready, the one-word holding stage is occupied and the output
// register is occupied and stalled. Reset clears the table (count zero),
// playback, the button history and both configuration registers; the table
// contents are left as they were and never used before being written.
// ----------------------------------------------------------------------------
module timed_event_sequencer_unit #(
  parameter int MAX_EVENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] now_ms,
  input  logic        button_pressed,
  input  logic [31:0] event_time,
  input  logic        event_is_stop,
  input  logic [7:0]  action_id,
  input  logic        has_action,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [7:0]  target_action,
  output logic        is_playing,
  output logic        last_result,
  input  logic        write_enable,
  input  logic        reg_index,
  input  logic [1:0]  write_data
);

  localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  tes_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  tes_pkg::entry_t mem_rdata;
  logic            out_free;
  logic            push;
  tes_pkg::res_t   push_word;
  tes_pkg::res_t   out_word;

  tes_ctrl #(
    .MAX_EVENTS(MAX_EVENTS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .now_ms        (now_ms),
    .button_pressed(button_pressed),
    .event_time    (event_time),
    .event_is_stop (event_is_stop),
    .action_id     (action_id),
    .has_action    (has_action),
    .write_enable  (write_enable),
    .reg_index     (reg_index),
    .write_data    (write_data),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .out_free      (out_free),
    .push          (push),
    .push_word     (push_word)
  );

  tes_mem #(
    .DEPTH(MAX_EVENTS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  tes_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (push),
    .word     (push_word),
    .free     (out_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  assign result_kind   = out_word.kind;
  assign target_action = out_word.act;
  assign is_playing    = out_word.playing;
  assign last_result   = out_word.last;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || !out_stall))
    else $error("result word loaded over a held word");

  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    push |-> in_stall)
    else $error("result word produced while no input word is in work");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (push && push_word.last) |=> !in_stall)
    else $error("input side not released after the final result word");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) < 32'(MAX_EVENTS)))
    else $error("event table write beyond its depth");

endmodule

// ----- tb/timed_event_sequencer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event sequencer testbench
// Fills the event table through directed words, then plays it back under
// every button mode and loop setting with random ticks, starts, stops and
// refused adds. Every result word is compared with a cycle-free model of the
// sequencer kept in this file, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module timed_event_sequencer_unit_tb;

  localparam int          TABLE_DEPTH    = 16;
  localparam logic [1:0]  MODE_UNUSED    = 2'd3;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          SETTLE_CYCLES  = 30;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          PRINT_LIMIT    = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = tes_pkg::OP_TICK;
  logic [31:0] now_ms = '0;
  logic        button_pressed = 1'b0;
  logic [31:0] event_time = '0;
  logic        event_is_stop = 1'b0;
  logic [7:0]  action_id = '0;
  logic        has_action = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  result_kind;
  logic [7:0]  target_action;
  logic        is_playing;
  logic        last_result;
  logic        write_enable = 1'b0;
  logic        reg_index = tes_pkg::REG_BUTTON_MODE;
  logic [1:0]  write_data = '0;

  logic [31:0] ev_time [TABLE_DEPTH];
  logic        ev_stop [TABLE_DEPTH];
  logic        ev_has  [TABLE_DEPTH];
  logic [7:0]  ev_act  [TABLE_DEPTH];
  int unsigned ev_count = 0;
  int unsigned ev_next = 0;
  logic        play_on = 1'b0;
  logic        held_on = 1'b0;
  logic        btn_prev = 1'b0;
  logic [31:0] play_origin = '0;
  logic [1:0]  cfg_mode = tes_pkg::MODE_DIRECT;
  logic        cfg_loop = 1'b0;

  tes_pkg::res_t outgoing_words [$];
  tes_pkg::res_t item_words [$];

  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          stall_pct = 0;
  int          gap_max = 0;
  int          burst_left = 0;
  int          btn_flip_pct = 10;
  logic [31:0] wall_ms = '0;
  logic        btn_level = 1'b0;
  logic        hold_trigger = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  timed_event_sequencer_unit #(.MAX_EVENTS(TABLE_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .now_ms(now_ms),
    .button_pressed(button_pressed),
    .event_time(event_time),
    .event_is_stop(event_is_stop),
    .action_id(action_id),
    .has_action(has_action),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .target_action(target_action),
    .is_playing(is_playing),
    .last_result(last_result),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data)
  );

  always #4 clk = ~clk;

  function automatic void push_command(logic [2:0] kind, logic [7:0] act);
    tes_pkg::res_t w;
    if (item_words.size() < tes_pkg::MAX_RESULTS) begin
      w.kind    = kind;
      w.act     = act;
      w.playing = 1'b0;
      w.last    = 1'b0;
      item_words.push_back(w);
    end
  endfunction

  function automatic void restart_playback(logic [31:0] now);
    play_on     = 1'b1;
    play_origin = now;
    ev_next     = 0;
  endfunction

  function automatic void halt_all();
    play_on = 1'b0;
    for (int i = 0; i < ev_count; i++) begin
      if (ev_has[i]) begin
        push_command(tes_pkg::KIND_STOP, ev_act[i]);
      end
    end
  endfunction

  function automatic void insert_event(logic [31:0] t, logic stop, logic [7:0] act,
                                       logic has);
    int unsigned pos;
    if (ev_count >= TABLE_DEPTH) begin
      push_command(tes_pkg::KIND_REFUSED, 8'd0);
      return;
    end
    pos = ev_count;
    while (pos > 0 && ev_time[pos - 1] > t) begin
      ev_time[pos] = ev_time[pos - 1];
      ev_stop[pos] = ev_stop[pos - 1];
      ev_has[pos]  = ev_has[pos - 1];
      ev_act[pos]  = ev_act[pos - 1];
      pos--;
    end
    ev_time[pos] = t;
    ev_stop[pos] = stop;
    ev_has[pos]  = has;
    ev_act[pos]  = act;
    ev_count++;
    push_command(tes_pkg::KIND_ADDED, 8'd0);
  endfunction

  function automatic void advance_tick(logic [31:0] now, logic btn);
    logic [31:0] elapsed;
    if (cfg_mode == tes_pkg::MODE_DIRECT) begin
      if (btn && !held_on && !btn_prev) begin
        held_on = 1'b1;
        restart_playback(now);
      end else if (!btn && held_on && btn_prev) begin
        held_on = 1'b0;
        halt_all();
      end
    end else if (cfg_mode == tes_pkg::MODE_TOGGLE) begin
      if (btn && !held_on && !btn_prev) begin
        held_on = 1'b1;
        restart_playback(now);
      end else if (btn && held_on && !btn_prev) begin
        held_on = 1'b0;
        halt_all();
      end
    end else if (cfg_mode == tes_pkg::MODE_ONESHOT) begin
      if (btn && !btn_prev) begin
        restart_playback(now);
      end
    end
    btn_prev = btn;
    if (!play_on || ev_count == 0) begin
      return;
    end
    elapsed = now - play_origin;
    while (ev_next < ev_count && ev_time[ev_next] <= elapsed) begin
      if (ev_has[ev_next]) begin
        push_command(ev_stop[ev_next] ? tes_pkg::KIND_STOP : tes_pkg::KIND_TRIG,
                     ev_act[ev_next]);
      end
      ev_next++;
    end
    if (ev_next >= ev_count) begin
      if (cfg_loop) begin
        restart_playback(now);
      end else begin
        play_on = 1'b0;
      end
    end
  endfunction

  function automatic void predict_word(logic [1:0] op, logic [31:0] now, logic btn,
                                       logic [31:0] et, logic stop, logic [7:0] act,
                                       logic has);
    item_words.delete();
    case (op)
      tes_pkg::OP_ADD: begin
        insert_event(et, stop, act, has);
      end
      tes_pkg::OP_TICK: begin
        advance_tick(now, btn);
      end
      tes_pkg::OP_START: begin
        restart_playback(now);
      end
      default: begin
        halt_all();
      end
    endcase
    if (item_words.size() == 0) begin
      push_command(tes_pkg::KIND_NONE, 8'd0);
    end
    foreach (item_words[k]) begin
      item_words[k].playing = play_on;
      item_words[k].last    = (k == item_words.size() - 1);
      outgoing_words.push_back(item_words[k]);
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : check_words
    tes_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (outgoing_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d action %0d",
                                  result_kind, target_action));
      end else begin
        want = outgoing_words.pop_front();
        if (result_kind !== want.kind) begin
          report_mismatch($sformatf("result_kind %0d, expected %0d",
                                    result_kind, want.kind));
        end
        if (target_action !== want.act) begin
          report_mismatch($sformatf("target_action %0d, expected %0d",
                                    target_action, want.act));
        end
        if (is_playing !== want.playing) begin
          report_mismatch($sformatf("is_playing %b, expected %b",
                                    is_playing, want.playing));
        end
        if (last_result !== want.last) begin
          report_mismatch($sformatf("last_result %b, expected %b",
                                    last_result, want.last));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic [31:0] now, logic btn, logic [31:0] et,
                           logic stop, logic [7:0] act, logic has);
    opcode         = op;
    now_ms         = now;
    button_pressed = btn;
    event_time     = et;
    event_is_stop  = stop;
    action_id      = act;
    has_action     = has;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_word(op, now, btn, et, stop, act, has);
    @(negedge clk);
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(negedge clk);
        burst_left = $urandom_range(12, 1);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (outgoing_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [1:0] value);
    write_enable = 1'b1;
    reg_index    = idx;
    write_data   = value;
    @(negedge clk);
    write_enable = 1'b0;
    if (idx == tes_pkg::REG_BUTTON_MODE) begin
      cfg_mode = value;
    end else begin
      cfg_loop = value[0];
    end
  endtask

  task automatic random_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      wall_ms = $urandom();
    end else begin
      wall_ms = wall_ms + $urandom_range(40);
    end
    if ($urandom_range(99) < btn_flip_pct) begin
      btn_level = !btn_level;
    end
    if (pick < 72) begin
      send_word(tes_pkg::OP_TICK, wall_ms, btn_level, $urandom(), 1'($urandom_range(1)),
                8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (pick < 82) begin
      send_word(tes_pkg::OP_START, wall_ms, btn_level, $urandom(), 1'($urandom_range(1)),
                8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (pick < 90) begin
      send_word(tes_pkg::OP_STOP, wall_ms, btn_level, $urandom(), 1'($urandom_range(1)),
                8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      send_word(tes_pkg::OP_ADD, $urandom(), 1'($urandom_range(1)), $urandom(),
                1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_empty_table();
    send_word(tes_pkg::OP_TICK, 32'd5, 1'b1, $urandom(), 1'b0, 8'd0, 1'b0);
    send_word(tes_pkg::OP_TICK, 32'd6, 1'b0, $urandom(), 1'b0, 8'd0, 1'b0);
    send_word(tes_pkg::OP_START, 32'hFFFF_FFFF, 1'b0, $urandom(), 1'b1, 8'hFF, 1'b1);
    send_word(tes_pkg::OP_STOP, 32'd0, 1'b1, $urandom(), 1'b1, 8'hFF, 1'b1);
  endtask

  task automatic test_table_fill();
    logic [31:0] fill_times [TABLE_DEPTH] = '{
      32'd200, 32'd100, 32'd0,   32'd100, 32'd50,  32'd300, 32'h8000_0000, 32'd100,
      32'd25,  32'd250, 32'd150, 32'd0,   32'd75,  32'd175, 32'd275,       32'd125};
    logic [3:0] n;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      n = 4'(i);
      send_word(tes_pkg::OP_ADD, $urandom(), 1'($urandom_range(1)), fill_times[i],
                (i % 3 == 1), {n, n}, (i % 5 != 3));
    end
    send_word(tes_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1);
  endtask

  task automatic test_stop_and_sweep();
    send_word(tes_pkg::OP_STOP, 32'd0, 1'b0, 32'd0, 1'b0, 8'd0, 1'b0);
    send_word(tes_pkg::OP_START, 32'd0, 1'b0, 32'd0, 1'b0, 8'd0, 1'b0);
    send_word(tes_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, 8'd0, 1'b0);
  endtask

  task automatic test_unused_mode();
    wait_idle();
    write_reg(tes_pkg::REG_BUTTON_MODE, MODE_UNUSED);
    write_reg(tes_pkg::REG_LOOP_ENABLE, 2'd1);
    send_word(tes_pkg::OP_TICK, 32'd1000, 1'b1, $urandom(), 1'b0, 8'd0, 1'b0);
    send_word(tes_pkg::OP_START, 32'd1000, 1'b1, $urandom(), 1'b0, 8'd0, 1'b0);
    send_word(tes_pkg::OP_TICK, 32'd1010, 1'b0, $urandom(), 1'b0, 8'd0, 1'b0);
  endtask

  task automatic test_playback();
    logic [1:0] modes  [7] = '{tes_pkg::MODE_DIRECT, tes_pkg::MODE_TOGGLE,
                               tes_pkg::MODE_ONESHOT, tes_pkg::MODE_ONESHOT,
                               tes_pkg::MODE_DIRECT, tes_pkg::MODE_TOGGLE, MODE_UNUSED};
    logic       loops  [7] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    int         stalls [7] = '{30, 0, 50, 20, 70, 10, 40};
    int         gaps   [7] = '{20, 0, 8, 30, 4, 15, 10};
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      write_reg(tes_pkg::REG_BUTTON_MODE, modes[p]);
      write_reg(tes_pkg::REG_LOOP_ENABLE, {1'b0, loops[p]});
      stall_pct    = stalls[p];
      gap_max      = gaps[p];
      btn_flip_pct = (modes[p] == tes_pkg::MODE_DIRECT) ? 6 : 15;
      if (p == 3) begin
        wall_ms = 32'hFFFF_FF00;
      end
      repeat (60) random_word();
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    stall_pct    = 0;
    gap_max      = 0;
    hold_trigger = !hold_trigger;
    repeat (24) begin
      if ($urandom_range(1)) begin
        send_word(tes_pkg::OP_STOP, wall_ms, btn_level, $urandom(), 1'($urandom_range(1)),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        random_word();
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst       = 1'b0;
    stall_pct = 25;
    gap_max   = 6;
    test_empty_table();
    test_table_fill();
    test_stop_and_sweep();
    test_unused_mode();
    test_playback();
    test_backpressure();
    wait_idle();
    if (mismatches == 0 && outgoing_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
